[hdl/akc_pkg.sv]
// ----------------------------------------------------------------------------
// akc_pkg: shared types and constants of the ARGB convolution block
// Holds command codes, border modes, register indexes and state types.
// ----------------------------------------------------------------------------
package akc_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_RADIUS_DEF = 2;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int PIX_W  = 32;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 64;
    localparam int NCOEF  = 25;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] BM_CLAMP  = 2'd0;
    localparam logic [1:0] BM_WRAP   = 2'd1;
    localparam logic [1:0] BM_MIRROR = 2'd2;

    localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_BORDER = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RADIUS = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BANK_A = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BANK_B = 3'd5;
    localparam logic [CFG_IW-1:0] REG_BANK_C = 3'd6;
    localparam logic [CFG_IW-1:0] REG_BANK_D = 3'd7;

    typedef struct packed {
        logic           cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] argb_in;
    } akc_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] argb_out;
    } akc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DIV,
        ST_OUT
    } akc_state_t;

endpackage

[hdl/akc_if.sv]
// ----------------------------------------------------------------------------
// akc_if: valid/ready channel carrying one payload beat
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface akc_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/akc_div.sv]
// ----------------------------------------------------------------------------
// akc_div: signed restoring divider, truncating toward zero
// One quotient bit per cycle; start loads operands, done pulses with quotient.
// ----------------------------------------------------------------------------
module akc_div #(
    parameter int NW = 20,
    parameter int DW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DW-1:0], q_reg[NW-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = num[NW-1] ? NW'(-num) : num;
            d_next    = den[DW-1] ? DW'(-den) : den;
            neg_next  = num[NW-1] ^ den[DW-1];
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? NW'(-q_reg) : q_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("divider done without busy");
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("divider done while busy");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> cnt_reg == '0 || $past(start))
        else $error("divider count left over");
`endif
endmodule

[hdl/argb_kernel_convolution_top.sv]
// ----------------------------------------------------------------------------
// argb_kernel_convolution_top: ARGB frame store with square convolution
// Load beats write a pixel; query beats return the filtered pixel.
// ----------------------------------------------------------------------------
//  channel | dir | payload                  | beat
//  in_ch   | in  | cmd, col, row, argb_in   | valid & ready
//  out_ch  | out | argb_out                 | valid & ready
//  cfg     | in  | cfg_we, cfg_index, data  | cfg_we
//
//  A load is taken while idle. A query reads the side*side kernel window from
//  memory (one read per cycle on the single read port), then runs the serial
//  divider once per channel, or skips it when the kernel sum is zero, then
//  presents the output. A query outside the image answers with zero. Reset
//  clears control state only; the frame store is undefined until loaded. A
//  stalled output holds the result; input is refused until it is taken.
// ----------------------------------------------------------------------------
module argb_kernel_convolution_top
    import akc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    akc_if.sink                          in_ch,
    akc_if.source                        out_ch,
    input  logic                         cfg_we,
    input  logic [akc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [akc_pkg::CFG_DW-1:0]   cfg_data
);
    import akc_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XP    = (XW > 0 ? XW : 1);
    localparam int AW    = XP + (YW > 0 ? YW : 1);
    localparam int DEPTH = 1 << AW;
    localparam int SW    = 13;
    localparam int ACCW  = 21;
    localparam int KW    = 5;

    logic [6:0]    width_reg, height_reg;
    logic [1:0]    border_reg, radius_reg;
    logic [199:0]  coef_reg;

    akc_state_t    state_reg, state_next;
    logic [COL_W-1:0] qx_reg, qx_next;
    logic [ROW_W-1:0] qy_reg, qy_next;
    logic [2:0]    kx_reg, kx_next, ky_reg, ky_next;
    logic [KW-1:0] k_reg, k_next, kd_reg, kd_next;
    logic signed [ACCW-1:0] acc_reg [4], acc_next [4];
    logic signed [SW-1:0]   ksum_reg, ksum_next;
    logic [1:0]    ch_reg, ch_next;
    logic [PIX_W-1:0] res_reg, res_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          div_start;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic [AW-1:0]    raddr;

    logic [6:0]  w_eff, h_eff;
    logic [2:0]  r_eff, side;
    logic        query_out;
    logic signed [8:0] px_c, py_c;
    logic [6:0]  px_m, py_m;
    logic signed [ACCW-1:0] quo;
    logic        div_busy, div_done;
    logic signed [ACCW-1:0] cur_acc;
    logic signed [7:0] coef_d;
    logic [7:0]  sat_v;

    function automatic logic [6:0] map_c(input logic signed [8:0] c,
                                         input logic [6:0] dim,
                                         input logic [1:0] mode);
        logic signed [8:0] v;
        logic signed [8:0] d;
        begin
            d = {2'b00, dim};
            v = c;
            if (mode == BM_WRAP)
            begin
                if (v < 0)
                    v = v + d;
                else if (v >= d)
                    v = v - d;
                if (v < 0)
                    v = v + d;
                else if (v >= d)
                    v = v - d;
            end
            else
            begin
                if (mode == BM_MIRROR)
                begin
                    if (v < 0)
                        v = -v;
                    else if (v >= d)
                        v = 9'sd2 * d - 9'sd2 - v;
                end
                if (v < 0)
                    v = '0;
                if (v >= d)
                    v = d - 9'sd1;
            end
            map_c = v[6:0];
        end
    endfunction

    function automatic logic [7:0] sat8(input logic signed [ACCW-1:0] v);
        begin
            if (v < 0)
                sat8 = 8'd0;
            else if (v > 255)
                sat8 = 8'd255;
            else
                sat8 = v[7:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
            border_reg <= BM_CLAMP;
            radius_reg <= 2'd1;
            coef_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[6:0];
                REG_HEIGHT: height_reg <= cfg_data[6:0];
                REG_BORDER: border_reg <= cfg_data[1:0];
                REG_RADIUS: radius_reg <= cfg_data[1:0];
                REG_BANK_A: coef_reg[63:0]    <= cfg_data;
                REG_BANK_B: coef_reg[127:64]  <= cfg_data;
                REG_BANK_C: coef_reg[191:128] <= cfg_data;
                REG_BANK_D: coef_reg[199:192] <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 7'd0)
            w_eff = 7'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = 7'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 7'd0)
            h_eff = 7'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = 7'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        if (radius_reg == 2'd0)
            r_eff = 3'd1;
        else if (32'(radius_reg) > MAX_RADIUS)
            r_eff = 3'(MAX_RADIUS);
        else
            r_eff = {1'b0, radius_reg};
        side = 3'(2 * r_eff + 3'd1);
    end

    assign px_c = $signed({3'b000, qx_reg}) + $signed({6'b0, kx_reg})
                - $signed({6'b0, r_eff});
    assign py_c = $signed({3'b000, qy_reg}) + $signed({6'b0, ky_reg})
                - $signed({6'b0, r_eff});
    assign px_m = map_c(px_c, w_eff, border_reg);
    assign py_m = map_c(py_c, h_eff, border_reg);

    assign raddr = (AW'(py_m) << XP) | AW'(px_m);

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.payload.cmd == CMD_LOAD
            && 32'(in_ch.payload.col) < MAX_WIDTH
            && 32'(in_ch.payload.row) < MAX_HEIGHT)
            mem[(AW'(in_ch.payload.row) << XP) | AW'(in_ch.payload.col)]
                <= in_ch.payload.argb_in;
        rdata_reg <= mem[raddr];
    end

    assign coef_d = $signed(coef_reg[8*kd_reg +: 8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        kx_reg   <= kx_next;
        ky_reg   <= ky_next;
        k_reg    <= k_next;
        kd_reg   <= kd_next;
        ksum_reg <= ksum_next;
        ch_reg   <= ch_next;
        res_reg  <= res_next;
        for (int i = 0; i < 4; i++)
            acc_reg[i] <= acc_next[i];
    end

    assign cur_acc = acc_reg[ch_reg];
    assign sat_v   = sat8(div_done ? quo : cur_acc);
    assign query_out = 32'(in_ch.payload.col) >= 32'(w_eff)
                    || 32'(in_ch.payload.row) >= 32'(h_eff);

    always_comb
    begin
        state_next  = state_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        kx_next     = kx_reg;
        ky_next     = ky_reg;
        k_next      = k_reg;
        kd_next     = k_reg;
        ksum_next   = ksum_reg;
        ch_next     = ch_reg;
        res_next    = res_reg;
        rd_vld_next = 1'b0;
        div_start   = 1'b0;
        for (int i = 0; i < 4; i++)
            acc_next[i] = acc_reg[i];
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;

        if (rd_vld_reg)
        begin
            ksum_next = ksum_reg + SW'(coef_d);
            for (int i = 0; i < 4; i++)
                acc_next[i] = acc_reg[i]
                    + ACCW'($signed({1'b0, rdata_reg[8*i +: 8]})) * ACCW'(coef_d);
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid && in_ch.payload.cmd == CMD_QUERY)
                begin
                    qx_next   = in_ch.payload.col;
                    qy_next   = in_ch.payload.row;
                    kx_next   = '0;
                    ky_next   = '0;
                    k_next    = '0;
                    ksum_next = '0;
                    ch_next   = '0;
                    for (int i = 0; i < 4; i++)
                        acc_next[i] = '0;
                    if (query_out)
                    begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_vld_next = 1'b1;
                k_next = k_reg + 1'b1;
                if (kx_reg == side - 3'd1)
                begin
                    kx_next = '0;
                    ky_next = ky_reg + 1'b1;
                    if (ky_reg == side - 3'd1)
                        state_next = ST_LAST;
                end
                else
                    kx_next = kx_reg + 1'b1;
            end
            ST_LAST:
            begin
                if (!rd_vld_reg)
                begin
                    state_next = ST_DIV;
                    if (ksum_reg != 0)
                        div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (ksum_reg == 0 || div_done)
                begin
                    res_next[8*ch_reg +: 8] = sat_v;
                    ch_next = ch_reg + 1'b1;
                    if (ch_reg == 2'd3)
                        state_next = ST_OUT;
                    else if (ksum_reg != 0)
                        div_start = 1'b1;
                end
            end
            ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (state_reg == ST_DIV && ksum_reg == 0)
            res_next[8*ch_reg +: 8] = sat8(cur_acc);
    end

    assign out_ch.payload.argb_out = res_reg;

    akc_div #(
        .NW (ACCW),
        .DW (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_next[ch_next]),
        .den   (ksum_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (quo)
    );

`ifndef SYNTHESIS
    a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("input taken while busy");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result dropped under stall");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider runs outside divide phase");
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> k_reg < 5'd25)
        else $error("kernel index overrun");
`endif
endmodule
